/* src/bitvector_interning_store_defines.svh */
// Assertion macros for the interning store.
// BIS_ASSERT checks a condition at every clock edge outside reset.
// BIS_ASSERT_NEXT checks a consequence in the cycle after its trigger.
`ifndef BITVECTOR_INTERNING_STORE_DEFINES_SVH
`define BITVECTOR_INTERNING_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BIS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BIS_ASSERT(lbl, cond, msg)
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/bis_pkg.sv */
package bis_pkg;

    // Sizes of the store; INDEX_SLOTS must be a power of two
    localparam int WORDS       = 4;
    localparam int ENTRIES     = 256;
    localparam int INDEX_SLOTS = 512;

    localparam int WCNT_W  = $clog2(WORDS + 1);
    localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ID_W    = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = $clog2(INDEX_SLOTS);
    localparam int PRB_W   = $clog2(INDEX_SLOTS + 1);
    localparam int SADDR_W = (ENTRIES * WORDS > 1) ? $clog2(ENTRIES * WORDS) : 1;
    localparam int BAG_W   = 8;

    localparam logic [63:0] ONES64   = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] MIX_C1   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_C2   = 64'h94d0_49bb_1331_11eb;

    // Result status codes
    localparam logic [1:0] ST_OLD     = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_COLLIDE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // One assembled vector, ready for lookup
    typedef struct packed {
        logic [WORDS-1:0][63:0] words;
        logic [63:0]            fold;
        logic                   zero;
        logic                   ones;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic clr_done;
    } t_bk_stat;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_MUL, S_PRD, S_PCHK, S_CRD, S_CCHK, S_WR
    } t_bstate;

endpackage

/* src/bitvector_interning_store.sv */
// Channel  Dir  Handshake                     Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata[63:0] vector_word, tlast last_word
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata[7:0] bag_id, tdata[9:8] status
//
// Words are taken one per cycle while the job queue has room. After the last word, lookup
// runs the two SplitMix64 multiplies (three 32x32 partial products each, one multiplier),
// then a read and a check per index probe, then a read and a check per compared word on
// a hit or a write per stored word on a miss; zero and all-ones vectors answer from idle.
// After reset a pass clears every index slot; no words are taken until it ends.
// A two-deep job queue lets words stream in while the back end probes.
`include "bitvector_interning_store_defines.svh"
module bitvector_interning_store
    import bis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] vector_word
    input  logic        i_s_axis_tlast,   // last_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [7:0] bag_id, [9:8] status, rest zero
);

    t_job             push_job, head_job;
    logic             push, pop;
    t_q_stat          q_stat;
    t_bk_stat         bk_stat;
    logic [BAG_W-1:0] bag_id;
    logic [1:0]       status;

    bis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_word    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_ready   (o_s_axis_tready),
        .i_q_stat  (q_stat),
        .i_bk_stat (bk_stat),
        .o_push    (push),
        .o_job     (push_job)
    );

    bis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    bis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_bk_stat   (bk_stat),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_bag_id    (bag_id),
        .o_status    (status)
    );

    assign o_m_axis_tdata = {6'd0, status, bag_id};

    // Checks on results and on input ready
    `BIS_ASSERT(a_full_id0, !o_m_axis_tvalid || status != ST_FULL || bag_id == 8'd0, "full with id")
    `BIS_ASSERT(a_new_id, !o_m_axis_tvalid || status != ST_NEW || bag_id > 8'd1, "new id reserved")
    `BIS_ASSERT(a_col_id, !o_m_axis_tvalid || status != ST_COLLIDE || bag_id > 8'd1, "collide reserved")
    `BIS_ASSERT_NEXT(a_rdy_clr, o_s_axis_tready, bk_stat.clr_done, "ready during clear")

endmodule

/* src/bis_front.sv */
module bis_front
    import bis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_word,
    input  logic        i_last,
    output logic        o_ready,
    input  t_q_stat     i_q_stat,
    input  t_bk_stat    i_bk_stat,
    output logic        o_push,
    output t_job        o_job
);

    logic [WORDS-1:0][63:0] r_buf, n_buf;
    logic [63:0]            r_fold, n_fold;
    logic                   r_zero, n_zero, r_ones, n_ones;
    logic [WCNT_W-1:0]      r_cnt, n_cnt;
    logic                   accept;

    assign o_ready = !i_q_stat.full && i_bk_stat.clr_done;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_last;

    // Fold the incoming word into the vector; drop words past the end
    always_comb begin
        n_buf  = r_buf;
        n_fold = r_fold;
        n_zero = r_zero;
        n_ones = r_ones;
        n_cnt  = r_cnt;
        if (r_cnt < WCNT_W'(WORDS)) begin
            n_buf[r_cnt[WIDX_W-1:0]] = i_word;
            n_fold = r_fold ^ i_word;
            if (i_word != 64'd0) n_zero = 1'b0;
            if (i_word != ONES64) n_ones = 1'b0;
            n_cnt = r_cnt + WCNT_W'(1);
        end
    end

    // A short vector is never all ones
    always_comb begin
        o_job.words = n_buf;
        o_job.fold  = n_fold;
        o_job.zero  = n_zero;
        o_job.ones  = n_ones && (n_cnt == WCNT_W'(WORDS));
    end

    // Hold the partial vector; clear it after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_buf  <= '0;
            r_fold <= '0;
            r_zero <= 1'b1;
            r_ones <= 1'b1;
            r_cnt  <= '0;
        end else if (accept) begin
            r_buf  <= n_buf;
            r_fold <= n_fold;
            r_zero <= n_zero;
            r_ones <= n_ones;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* src/bis_queue.sv */
module bis_queue
    import bis_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // Store a pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // Advance pointers and the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* src/bis_back.sv */
module bis_back
    import bis_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_job,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    output t_bk_stat         o_bk_stat,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [BAG_W-1:0] o_bag_id,
    output logic [1:0]       o_status
);

    // Memories
    logic [63:0]   r_store [ENTRIES*WORDS];
    logic [63:0]   r_key   [INDEX_SLOTS];
    logic [ID_W:0] r_meta  [INDEX_SLOTS];
    logic [63:0]   r_sdat_q, r_key_q;
    logic [ID_W:0] r_meta_q;

    t_bstate           r_state, n_state;
    logic [SLOT_W-1:0] r_clr, r_slot, n_slot;
    logic [PRB_W-1:0]  r_probes, n_probes;
    logic [63:0]       r_z, n_z, r_acc, n_acc, r_h, n_h;
    logic [1:0]        r_step, n_step;
    logic              r_round, n_round;
    logic [ID_W-1:0]   r_id, n_id, r_count;
    logic [WIDX_W-1:0] r_w, n_w;
    logic              r_res_valid;
    logic [BAG_W-1:0]  r_res_id;
    logic [1:0]        r_res_st;

    logic              go, trivial, slot_valid, key_eq, probe_last, w_last, cnt_full;
    logic              mis, fin, ins;
    logic [BAG_W-1:0]  fin_id;
    logic [1:0]        fin_st;
    logic [31:0]       ma, mb;
    logic [63:0]       bconst, prod, mix_t;
    logic [SADDR_W-1:0] saddr;
    logic              store_we, meta_we;
    logic [SLOT_W-1:0] meta_addr;
    logic [ID_W:0]     meta_wd;

    assign go         = !i_q_stat.empty && !r_res_valid;
    assign trivial    = i_job.zero || i_job.ones;
    assign slot_valid = r_meta_q[ID_W];
    assign key_eq     = (r_key_q == r_h);
    assign probe_last = (r_probes == PRB_W'(INDEX_SLOTS - 1));
    assign w_last     = (r_w == WIDX_W'(WORDS - 1));
    assign cnt_full   = (r_count >= ID_W'(ENTRIES));
    assign mis        = (r_sdat_q != i_job.words[r_w]);
    assign n_slot     = (r_slot == SLOT_W'(INDEX_SLOTS - 1)) ? '0 : r_slot + SLOT_W'(1);

    // One 32x32 partial product a cycle toward the low half of a 64x64 product
    assign bconst = r_round ? MIX_C2 : MIX_C1;
    assign ma     = (r_step == 2'd1) ? r_z[63:32] : r_z[31:0];
    assign mb     = (r_step == 2'd2) ? bconst[63:32] : bconst[31:0];
    assign prod   = 64'(ma) * 64'(mb);
    assign mix_t  = r_acc + {prod[31:0], 32'd0};

    assign saddr  = SADDR_W'(r_id) * SADDR_W'(WORDS) + SADDR_W'(r_w);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == SLOT_W'(INDEX_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE: if (go && !trivial) n_state = S_MUL;
            S_MUL:  if (r_step == 2'd2 && r_round) n_state = S_PRD;
            S_PRD:  n_state = S_PCHK;
            S_PCHK: begin
                if (!slot_valid)     n_state = cnt_full ? S_IDLE : S_WR;
                else if (key_eq)     n_state = S_CRD;
                else if (probe_last) n_state = S_IDLE;
                else                 n_state = S_PRD;
            end
            S_CRD:  n_state = S_CCHK;
            S_CCHK: if (mis || w_last) n_state = S_IDLE; else n_state = S_CRD;
            S_WR:   if (w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result outputs
    always_comb begin
        n_z      = r_z;
        n_acc    = r_acc;
        n_h      = r_h;
        n_step   = r_step;
        n_round  = r_round;
        n_id     = r_id;
        n_w      = r_w;
        n_probes = r_probes;
        fin      = 1'b0;
        fin_id   = '0;
        fin_st   = ST_OLD;
        store_we = 1'b0;
        ins      = 1'b0;
        unique case (r_state)
            S_IDLE: if (go) begin
                if (trivial) begin
                    fin    = 1'b1;
                    fin_id = i_job.zero ? BAG_W'(0) : BAG_W'(1);
                end else begin
                    n_z     = i_job.fold ^ (i_job.fold >> 30);
                    n_step  = 2'd0;
                    n_round = 1'b0;
                end
            end
            S_MUL: begin
                if (r_step == 2'd0) begin
                    n_acc  = prod;
                    n_step = 2'd1;
                end else if (r_step == 2'd1) begin
                    n_acc  = mix_t;
                    n_step = 2'd2;
                end else begin
                    n_step = 2'd0;
                    if (!r_round) begin
                        n_z     = mix_t ^ (mix_t >> 27);
                        n_round = 1'b1;
                    end else begin
                        n_h      = mix_t ^ (mix_t >> 31);
                        n_probes = '0;
                    end
                end
            end
            S_PCHK: begin
                n_probes = r_probes + PRB_W'(1);
                if (!slot_valid) begin
                    if (cnt_full) begin
                        fin    = 1'b1;
                        fin_st = ST_FULL;
                    end else begin
                        n_id = r_count;
                        n_w  = '0;
                    end
                end else if (key_eq) begin
                    n_id = r_meta_q[ID_W-1:0];
                    n_w  = '0;
                end else if (probe_last) begin
                    fin    = 1'b1;
                    fin_st = ST_FULL;
                end
            end
            S_CCHK: begin
                if (mis || w_last) begin
                    fin    = 1'b1;
                    fin_id = BAG_W'(r_id);
                    fin_st = mis ? ST_COLLIDE : ST_OLD;
                end else begin
                    n_w = r_w + WIDX_W'(1);
                end
            end
            S_WR: begin
                store_we = 1'b1;
                if (w_last) begin
                    ins    = 1'b1;
                    fin    = 1'b1;
                    fin_id = BAG_W'(r_id);
                    fin_st = ST_NEW;
                end else begin
                    n_w = r_w + WIDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_pop     = fin;
    assign meta_we   = (r_state == S_CLR) || ins;
    assign meta_addr = (r_state == S_CLR) ? r_clr : r_slot;
    assign meta_wd   = (r_state == S_CLR) ? '0 : {1'b1, r_id};

    // Vector store: one word a cycle
    always_ff @(posedge i_clk) begin
        if (store_we) r_store[saddr] <= i_job.words[r_w];
        r_sdat_q <= r_store[saddr];
    end

    // Index: valid and id per slot, and the stored hash
    always_ff @(posedge i_clk) begin
        if (meta_we) r_meta[meta_addr] <= meta_wd;
        if (ins) r_key[r_slot] <= r_h;
        r_meta_q <= r_meta[r_slot];
        r_key_q  <= r_key[r_slot];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_count     <= ID_W'(2);
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + SLOT_W'(1);
            if (ins) r_count <= r_count + ID_W'(1);
            if (fin) r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_z      <= n_z;
        r_acc    <= n_acc;
        r_h      <= n_h;
        r_step   <= n_step;
        r_round  <= n_round;
        r_id     <= n_id;
        r_w      <= n_w;
        r_probes <= n_probes;
        if (r_state == S_MUL && r_step == 2'd2 && r_round)
            r_slot <= n_h[SLOT_W-1:0];
        else if (r_state == S_PCHK)
            r_slot <= (slot_valid && !key_eq) ? n_slot : r_slot;
        if (fin) begin
            r_res_id <= fin_id;
            r_res_st <= fin_st;
        end
    end

    assign o_res_valid        = r_res_valid;
    assign o_bag_id           = r_res_id;
    assign o_status           = r_res_st;
    assign o_bk_stat.clr_done = (r_state != S_CLR);

endmodule

/* tb/sv/interning_checker.sv */
module interning_checker
    import bis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] vector_word
    input  logic        i_s_axis_tlast,   // last_word
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [7:0] bag_id, [9:8] status
    output int          o_failures,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] bag_id;
        logic [1:0] status;
    } t_answer;

    // Mirror of the store, its index and the vector being assembled
    logic [WORDS-1:0][63:0] stored_vec [ENTRIES];
    logic [63:0]            slot_hash  [INDEX_SLOTS];
    logic [ID_W-1:0]        slot_id    [INDEX_SLOTS];
    logic                   slot_used  [INDEX_SLOTS];
    int                     next_id;
    logic [WORDS-1:0][63:0] asm_words;
    logic [63:0]            asm_fold;
    logic                   asm_zero;
    logic                   asm_ones;
    int                     asm_count;

    t_answer answers_due [$];
    int      seen_status [4];

    function automatic logic [63:0] splitmix_final(input logic [63:0] z);
        z = z ^ (z >> 30);
        z = z * 64'hbf58_476d_1ce4_e5b9;
        z = z ^ (z >> 27);
        z = z * 64'h94d0_49bb_1331_11eb;
        return z ^ (z >> 31);
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_failures++;
    endtask

    // Resolve a finished vector to its id and status, updating the store
    function automatic t_answer intern_vector();
        t_answer          ans;
        logic [63:0]      h;
        int               slot;
        int               probes;
        logic             ones;
        ones = asm_ones && (asm_count >= WORDS);
        if (asm_zero) return '{8'd0, ST_OLD};
        if (ones) return '{8'd1, ST_OLD};
        h = splitmix_final(asm_fold);
        slot = int'(h[SLOT_W-1:0]);
        for (probes = 0; probes < INDEX_SLOTS; probes++) begin
            if (!slot_used[slot]) break;
            if (slot_hash[slot] == h) begin
                ans.bag_id = slot_id[slot][7:0];
                ans.status = (stored_vec[slot_id[slot]] == asm_words) ? ST_OLD : ST_COLLIDE;
                return ans;
            end
            slot = (slot + 1) % INDEX_SLOTS;
        end
        if (probes == INDEX_SLOTS || next_id >= ENTRIES) return '{8'd0, ST_FULL};
        stored_vec[next_id] = asm_words;
        slot_hash[slot] = h;
        slot_id[slot] = ID_W'(next_id);
        slot_used[slot] = 1'b1;
        ans = '{8'(next_id), ST_NEW};
        next_id++;
        return ans;
    endfunction

    function automatic void clear_assembly();
        asm_words = '0;
        asm_fold = '0;
        asm_zero = 1'b1;
        asm_ones = 1'b1;
        asm_count = 0;
    endfunction

    initial begin
        o_failures = 0;
        for (int i = 0; i < 4; i++) seen_status[i] = 0;
    end

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            stored_vec[0] = '0;
            stored_vec[1] = '1;
            next_id = 2;
            clear_assembly();
            answers_due.delete();
        end else begin
            // Take one word of the vector under assembly
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (asm_count < WORDS) begin
                    asm_words[asm_count] = i_s_axis_tdata;
                    asm_fold ^= i_s_axis_tdata;
                    if (i_s_axis_tdata != '0) asm_zero = 1'b0;
                    if (i_s_axis_tdata != '1) asm_ones = 1'b0;
                    asm_count++;
                end
                if (i_s_axis_tlast) begin
                    answers_due.push_back(intern_vector());
                    clear_assembly();
                end
            end
            // Compare each result transfer with the oldest expectation
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.bag_id = i_m_axis_tdata[7:0];
                got.status = i_m_axis_tdata[9:8];
                if (answers_due.size() == 0) begin
                    report($sformatf("unexpected result id %0d status %0d",
                                     got.bag_id, got.status));
                end else begin
                    want = answers_due.pop_front();
                    seen_status[want.status]++;
                    if (got.bag_id !== want.bag_id)
                        report($sformatf("bag_id %0d, expected %0d", got.bag_id, want.bag_id));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, expected %0d", got.status, want.status));
                    if (i_m_axis_tdata[15:10] !== '0)
                        report("nonzero padding bits in result");
                end
            end
        end
    end

    task automatic print_summary();
        if (answers_due.size() != 0)
            report($sformatf("%0d results never arrived", answers_due.size()));
        $display("results: %0d existing/reserved, %0d added, %0d collisions, %0d store full",
                 seen_status[ST_OLD], seen_status[ST_NEW],
                 seen_status[ST_COLLIDE], seen_status[ST_FULL]);
    endtask

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import bis_pkg::*;

    localparam int RANDOM_WORDS = 1850;
    localparam int CALM_AFTER   = 1650;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic [5:0][63:0] w;
        logic [2:0]       len;
    } t_vec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          failures;
    int          pending;
    int          words_sent = 0;
    int          vectors_sent = 0;
    int          cycles = 0;
    logic        calm = 1'b0;
    t_vec        history [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bitvector_interning_store dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    interning_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_failures      (failures),
        .o_pending       (pending)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: stall in random bursts until the quiet tail
    initial begin
        @(posedge i_clk);
        m_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Words that hit the zero and all-ones tests often
    function automatic logic [63:0] sparse_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return rand_word();
        endcase
    endfunction

    // Move one word, with an optional gap ahead of it
    task automatic send_word(input logic [63:0] word, input logic last);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
        if (words_sent > CALM_AFTER) calm = 1'b1;
    endtask

    task automatic send_vector(input t_vec v);
        for (int i = 0; i < v.len; i++)
            send_word(v.w[i], i == v.len - 1);
        vectors_sent++;
        history.push_back(v);
        if (history.size() > 64) void'(history.pop_front());
    endtask

    function automatic t_vec filled(input logic [63:0] word, input int n);
        t_vec v;
        v.w = '0;
        for (int i = 0; i < n; i++) v.w[i] = word;
        v.len = 3'(n);
        return v;
    endfunction

    function automatic t_vec random_vec(input int n, input logic sparse);
        t_vec v;
        v.w = '0;
        for (int i = 0; i < n; i++) v.w[i] = sparse ? sparse_word() : rand_word();
        v.len = 3'(n);
        return v;
    endfunction

    // Reorder words: same fold, so same hash, usually different content
    function automatic t_vec swapped(input t_vec v);
        t_vec        r;
        logic [63:0] tmp;
        r = v;
        if (r.len < 2) r.len = 3'd2;
        tmp = r.w[0];
        r.w[0] = r.w[1];
        r.w[1] = tmp;
        return r;
    endfunction

    initial begin
        t_vec v;
        int   pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reserved ids, short and long vectors, repeats, collisions
        send_vector(filled('0, WORDS));
        send_vector(filled('1, WORDS));
        send_vector(filled('1, WORDS - 1));
        send_vector(filled('1, 6));
        send_vector(filled('0, 1));
        v = random_vec(WORDS, 1'b0);
        send_vector(v);
        send_vector(v);
        send_vector(swapped(v));
        v = random_vec(1, 1'b0);
        send_vector(v);
        send_vector(random_vec(6, 1'b0));
        send_vector(filled(64'h8000_0000_0000_0001, WORDS));
        send_vector(filled(64'h5555_5555_5555_5555, 2));
        send_vector(random_vec(WORDS, 1'b1));

        // Random vectors of one to six words, four words long most often
        while (words_sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                v = random_vec(WORDS, 1'b0);
            else if (pick < 55)
                v = random_vec($urandom_range(1, 6), 1'b1);
            else if (pick < 75)
                v = history[$urandom_range(0, history.size() - 1)];
            else if (pick < 85)
                v = swapped(history[$urandom_range(0, history.size() - 1)]);
            else if (pick < 90)
                v = filled('0, $urandom_range(1, 6));
            else if (pick < 95)
                v = filled('1, $urandom_range(1, 6));
            else
                v = random_vec($urandom_range(1, 6), 1'b0);
            send_vector(v);
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("sent %0d words in %0d vectors, incl. reserved, short, long and reordered",
                 words_sent, vectors_sent);
        chk.print_summary();
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
